// ===== hdl/hds_pkg.sv =====
package hds_pkg;

  // Line store geometry
  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int FILL_W      = $clog2(MAX_COLUMNS + 2);
  localparam int MIN_EDGE    = 3;

  // Fixed field widths
  localparam int VAL_W       = 32;
  localparam int ROW_W       = 16;
  localparam int OUT_COL_W   = 10;
  localparam int RAW_COL_W   = 11;
  localparam int RATIO_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DATA_W  = 64;

  // Stencil arithmetic widths
  localparam int LAP_W       = 36;
  localparam int PROD_W      = 53;
  localparam int RND_W       = 54;
  localparam int SUM_W       = 38;
  localparam int FRAC_SHIFT  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_RATIO = 2'd2;

  // Register reset values
  localparam logic [RAW_COL_W-1:0] COLS_RESET  = 11'd1024;
  localparam logic [ROW_W-1:0]     ROWS_RESET  = 16'd1024;
  localparam logic [RATIO_W-1:0]   RATIO_RESET = 16'd8192;

  // Position and frame tag of a reported cell
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } hds_meta_t;

  // Clamp the column count to what the line stores hold
  function automatic logic [FILL_W-1:0] clamp_cols(input logic [RAW_COL_W-1:0] raw);
    logic [FILL_W-1:0] res;
    if (int'(raw) < MIN_EDGE) begin
      res = FILL_W'(MIN_EDGE);
    end else if (int'(raw) > MAX_COLUMNS) begin
      res = FILL_W'(MAX_COLUMNS);
    end else begin
      res = FILL_W'(raw);
    end
    return res;
  endfunction

  // Clamp the row count to at least three
  function automatic logic [ROW_W-1:0] clamp_rows(input logic [ROW_W-1:0] raw);
    logic [ROW_W-1:0] res;
    if (int'(raw) < MIN_EDGE) begin
      res = ROW_W'(MIN_EDGE);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// ===== hdl/heat_diffusion_stencil_step.sv =====
// A reported cell passes through stage 1, stage 2, stage 3, stage 4 and the output register
// before it shows on out_; a stall on out_tready holds it in place.
// Each result belongs to the cell one row plus one column before the accepted word.
// Throughput: one word per clock unless out_tready stalls the pipeline; each cell word
// does one read and one write on each line store, a flush word only reads.
// Reset: synchronous, active low; clears counters, pipeline and registers to defaults.
// Line stores are not cleared; their entries are written before any result uses them.
module heat_diffusion_stencil_step import hds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VAL_W-1:0]      in_tdata,   // [31:0] cell_value
  input  logic                  in_tuser,   // [0] flush
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] new_value, [47:32] out_row,
                                            // [57:48] out_column, [63:58] zero
  output logic                  out_tlast,  // frame_last
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration
  logic [FILL_W-1:0]  cols_r;
  logic [ROW_W-1:0]   rows_r;
  logic [RATIO_W-1:0] ratio_r;

  // Raster position and fill level
  logic [COL_W-1:0]   col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  // Line stores
  logic [VAL_W-1:0]   prev_mem  [MAX_COLUMNS];
  logic [VAL_W-1:0]   older_mem [MAX_COLUMNS];
  logic [VAL_W-1:0]   prev_q, older_q;
  logic [VAL_W-1:0]   prev_rd, older_rd;
  logic               fwd_r;
  logic [VAL_W-1:0]   fwd_prev_r, fwd_older_r;

  // Window
  logic [VAL_W-1:0]   win_r   [9];
  logic [VAL_W-1:0]   win_nxt [9];

  // Stage 1: store read returns
  logic               v1_r, s1_flush_r, s1_emit_r, s1_border_r, s1_older_r;
  logic [COL_W-1:0]   s1_addr_r;
  logic [VAL_W-1:0]   s1_cell_r;
  hds_meta_t          s1_meta_r;

  // Stage 2: stencil operands
  logic               v2_r, s2_pass_r;
  logic signed [VAL_W-1:0] s2_n_r, s2_s_r, s2_w_r, s2_e_r, s2_c_r;
  hds_meta_t          s2_meta_r;

  // Stage 3: laplacian
  logic               v3_r, s3_pass_r;
  logic signed [LAP_W-1:0] s3_lap_r;
  logic signed [VAL_W-1:0] s3_c_r;
  hds_meta_t          s3_meta_r;

  // Stage 4: scaled laplacian
  logic               v4_r, s4_pass_r;
  logic signed [PROD_W-1:0] s4_prod_r;
  logic signed [VAL_W-1:0]  s4_c_r;
  hds_meta_t          s4_meta_r;

  // Output register
  logic               ov_r;
  logic [VAL_W-1:0]   out_val_r;
  hds_meta_t          out_meta_r;

  // Handshake and stage loads
  logic ld_out, ld4, ld3, ld2, ld1, in_fire, s1_wr, cfg_fire;

  // Acceptance-side decode
  logic               at_origin, fill_full, fl_emit, fl_older, d_emit;
  logic [COL_W-1:0]   cols_m1, rd_addr, d_ocol, f_ocol;
  logic [ROW_W-1:0]   rows_m1, d_orow, f_orow;
  logic               d_border, d_last;

  // Arithmetic
  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  sum;
  logic [VAL_W-1:0]         sat_val;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  // Chain the stage loads back from the output
  assign ld_out    = !ov_r || out_tready;
  assign ld4       = !v4_r || ld_out;
  assign ld3       = !v3_r || ld4;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;
  assign in_fire   = in_tvalid && ld1;
  assign s1_wr     = v1_r && ld2 && !s1_flush_r;

  // Decode the accepted word against the raster position
  always_comb begin
    cols_m1   = COL_W'(cols_r - 1'b1);
    rows_m1   = rows_r - 1'b1;
    at_origin = (row_cnt_r == '0) && (col_cnt_r == '0);
    fill_full = fill_r > cols_r;
    fl_emit   = at_origin && (fill_r != '0);
    fl_older  = fill_full;
    d_emit    = fill_full;

    // data: cell one row and one column back
    if (col_cnt_r != '0) begin
      d_ocol = col_cnt_r - 1'b1;
      d_orow = (row_cnt_r == '0) ? rows_m1 : row_cnt_r - 1'b1;
    end else begin
      d_ocol = cols_m1;
      if (row_cnt_r >= ROW_W'(2)) begin
        d_orow = row_cnt_r - ROW_W'(2);
      end else if (row_cnt_r == ROW_W'(1)) begin
        d_orow = rows_m1;
      end else begin
        d_orow = rows_r - ROW_W'(2);
      end
    end
    d_border = (d_orow == '0) || (d_orow == rows_m1) || (d_ocol == '0) || (d_ocol == cols_m1);
    d_last   = (d_orow == rows_m1) && (d_ocol == cols_m1);

    // flush: pending tail cell of the finished frame
    if (fl_older) begin
      f_orow = rows_r - ROW_W'(2);
      f_ocol = cols_m1;
    end else begin
      f_orow = rows_m1;
      f_ocol = COL_W'(cols_r - fill_r);
    end

    rd_addr = in_tuser ? f_ocol : col_cnt_r;
  end

  // Advance raster position and fill level
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    fill_nxt    = fill_r;
    if (in_tuser) begin
      if (fl_emit) begin
        fill_nxt = fill_r - 1'b1;
      end
    end else begin
      if (d_emit) begin
        fill_nxt = FILL_W'(cols_r + 1'b1);
      end else if (at_origin) begin
        fill_nxt = FILL_W'(1);
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
      if (FILL_W'(col_cnt_r) + 1'b1 >= cols_r) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (row_cnt_r == rows_m1) ? '0 : row_cnt_r + 1'b1;
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  // Configuration and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= clamp_cols(COLS_RESET);
      rows_r    <= clamp_rows(ROWS_RESET);
      ratio_r   <= RATIO_RESET;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      fill_r    <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_GRID_COLUMNS: begin
          cols_r    <= clamp_cols(cfg_data[RAW_COL_W-1:0]);
          col_cnt_r <= '0;
          row_cnt_r <= '0;
          fill_r    <= '0;
        end
        CFG_GRID_ROWS: begin
          rows_r    <= clamp_rows(cfg_data);
          col_cnt_r <= '0;
          row_cnt_r <= '0;
          fill_r    <= '0;
        end
        CFG_DIFFUSION_RATIO: begin
          ratio_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // Line stores: write back from stage 1, read on acceptance
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      prev_mem[s1_addr_r]  <= s1_cell_r;
      older_mem[s1_addr_r] <= prev_rd;
    end
    if (in_fire) begin
      prev_q  <= prev_mem[rd_addr];
      older_q <= older_mem[rd_addr];
    end
  end

  // Forward a write that lands on the edge of a read at the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_fire) begin
      fwd_r <= s1_wr && (s1_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_prev_r  <= s1_cell_r;
      fwd_older_r <= prev_rd;
    end
  end

  assign prev_rd  = fwd_r ? fwd_prev_r : prev_q;
  assign older_rd = fwd_r ? fwd_older_r : older_q;

  // Stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_flush_r  <= in_tuser;
      s1_emit_r   <= in_tuser ? fl_emit : d_emit;
      s1_border_r <= in_tuser ? 1'b1 : d_border;
      s1_older_r  <= fl_older;
      s1_addr_r   <= rd_addr;
      s1_cell_r   <= in_tdata;
      s1_meta_r.row  <= in_tuser ? f_orow : d_orow;
      s1_meta_r.col  <= OUT_COL_W'(in_tuser ? f_ocol : d_ocol);
      s1_meta_r.last <= in_tuser ? (fill_r == FILL_W'(1)) : d_last;
    end
  end

  // Shift the window by one column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3]     = win_r[k*3+1];
      win_nxt[k*3 + 1] = win_r[k*3+2];
    end
    win_nxt[2] = older_rd;
    win_nxt[5] = prev_rd;
    win_nxt[8] = s1_cell_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_wr) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  // Stage 2 capture: operands of the stencil
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_pass_r <= s1_border_r;
      s2_n_r    <= win_nxt[1];
      s2_s_r    <= win_nxt[7];
      s2_w_r    <= win_nxt[3];
      s2_e_r    <= win_nxt[5];
      if (s1_flush_r) begin
        s2_c_r <= s1_older_r ? older_rd : prev_rd;
      end else begin
        s2_c_r <= win_nxt[4];
      end
      s2_meta_r <= s1_meta_r;
    end
  end

  // Laplacian, exact
  assign lap = LAP_W'(s2_n_r) + LAP_W'(s2_s_r) + LAP_W'(s2_w_r) + LAP_W'(s2_e_r)
             - (LAP_W'(s2_c_r) <<< 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ld3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_pass_r <= s2_pass_r;
      s3_lap_r  <= lap;
      s3_c_r    <= s2_c_r;
      s3_meta_r <= s2_meta_r;
    end
  end

  // Scale by the diffusion ratio
  assign prod = PROD_W'(s3_lap_r) * PROD_W'($signed({1'b0, ratio_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (ld4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_pass_r <= s3_pass_r;
      s4_prod_r <= prod;
      s4_c_r    <= s3_c_r;
      s4_meta_r <= s3_meta_r;
    end
  end

  // Round half up, add to the center and saturate
  always_comb begin
    rnd = RND_W'(s4_prod_r) + RND_W'(32768);
    sum = SUM_W'(rnd >>> FRAC_SHIFT) + SUM_W'(s4_c_r);
    if (sum > SUM_W'(64'sd2147483647)) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (sum < -SUM_W'(64'sd2147483648)) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = VAL_W'(sum);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ld_out) begin
      ov_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_val_r  <= s4_pass_r ? s4_c_r : sat_val;
      out_meta_r <= s4_meta_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, out_meta_r.col, out_meta_r.row, out_val_r};
  assign out_tlast  = out_meta_r.last;

endmodule
